### src/srld_pkg.sv
`timescale 1ns / 1ps

package srld_pkg;

    // Default width of the element countdown.
    localparam int TOTAL_BITS_DEFAULT = 24;

    // Configuration register map.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 24;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIDE_FOUR   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ELEMENT_TOTAL = 1'd1;

    // Field widths.
    localparam int TOTAL_CFG_BITS = 24;
    localparam int ELEMENT_BITS   = 32;
    localparam int PARTIAL_BITS   = 24;
    localparam int COUNT_BITS     = 8;
    localparam int STATUS_BITS    = 3;

    // Stream status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_RUN_LONG  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_TRUNCATED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EXCESS    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_SHORT     = 3'd4;

    // Marker decoding constants.
    localparam logic [7:0] RUN_BIAS     = 8'd3;
    localparam logic [7:0] LITERAL_BIAS = 8'd1;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_MARKER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // One decoded result as it travels from the core to the output register.
    typedef struct packed {
        logic                    has_element;
        logic [ELEMENT_BITS-1:0] element_value;
        logic [COUNT_BITS-1:0]   repeat_count;
        logic                    stream_done;
        logic [STATUS_BITS-1:0]  status;
    } result_t;

endpackage

### src/srld_core.sv
`timescale 1ns / 1ps

module srld_core #(
    parameter int TOTAL_BITS = srld_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            step_byte,
    input  logic                  step_last,
    input  logic                  stride_four,
    input  logic [TOTAL_BITS-1:0] total_load,
    output logic                  result_valid,
    output srld_pkg::result_t     result
);

    import srld_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [TOTAL_BITS-1:0]    elements_left_reg, elements_left_next;
    logic [COUNT_BITS-1:0]    run_left_reg, run_left_next;
    logic [COUNT_BITS-1:0]    repeat_pending_reg, repeat_pending_next;
    logic [1:0]               byte_slot_reg, byte_slot_next;
    logic [PARTIAL_BITS-1:0]  partial_reg, partial_next;
    logic [STATUS_BITS-1:0]   error_reg, error_next;

    logic                     is_run;
    logic [COUNT_BITS-1:0]    marker_count;
    logic [ELEMENT_BITS-1:0]  merged;
    logic [COUNT_BITS-1:0]    run_left_dec;
    logic                     emit;

    assign is_run       = step_byte[7];
    assign marker_count = {1'b0, step_byte[6:0]} + (is_run ? RUN_BIAS : LITERAL_BIAS);
    assign merged       = {{(ELEMENT_BITS-PARTIAL_BITS){1'b0}}, partial_reg}
                        | ({{(ELEMENT_BITS-8){1'b0}}, step_byte} << {byte_slot_reg, 3'b000});
    assign run_left_dec = run_left_reg - 1'b1;

    always_comb
    begin
        phase_next          = phase_reg;
        elements_left_next  = elements_left_reg;
        run_left_next       = run_left_reg;
        repeat_pending_next = repeat_pending_reg;
        byte_slot_next      = byte_slot_reg;
        partial_next        = partial_reg;
        error_next          = error_reg;
        emit                = 1'b0;
        result              = '0;

        if (step && (error_reg == ST_OK))
        begin
            if (phase_reg == PH_START)
            begin
                elements_left_next = total_load;
                phase_next         = PH_MARKER;
            end
            if (phase_next == PH_MARKER)
            begin
                if (elements_left_next == '0)
                begin
                    error_next = ST_EXCESS;
                end
                else if ({{(TOTAL_BITS-COUNT_BITS){1'b0}}, marker_count} > elements_left_next)
                begin
                    error_next = ST_RUN_LONG;
                end
                else
                begin
                    elements_left_next  = elements_left_next
                                        - {{(TOTAL_BITS-COUNT_BITS){1'b0}}, marker_count};
                    run_left_next       = is_run ? 8'd1 : marker_count;
                    repeat_pending_next = is_run ? marker_count : 8'd1;
                    byte_slot_next      = 2'd0;
                    partial_next        = '0;
                    phase_next          = PH_DATA;
                end
            end
            else
            begin
                if (!stride_four || (byte_slot_reg == 2'd3))
                begin
                    emit                 = 1'b1;
                    result.element_value = merged;
                    result.repeat_count  = repeat_pending_reg;
                    byte_slot_next       = 2'd0;
                    partial_next         = '0;
                    run_left_next        = run_left_dec;
                    if (run_left_dec == '0)
                    begin
                        phase_next = PH_MARKER;
                    end
                end
                else
                begin
                    partial_next   = merged[PARTIAL_BITS-1:0];
                    byte_slot_next = byte_slot_reg + 2'd1;
                end
            end
        end

        result.has_element = emit;
        result.stream_done = step_last;
        if (step_last)
        begin
            if (error_next != ST_OK)
            begin
                result.status = error_next;
            end
            else if (phase_next == PH_DATA)
            begin
                result.status = ST_TRUNCATED;
            end
            else if (elements_left_next != '0)
            begin
                result.status = ST_SHORT;
            end
        end

        // The last byte closes the stream and returns all of its state to idle.
        if (step && step_last)
        begin
            phase_next          = PH_START;
            elements_left_next  = '0;
            run_left_next       = '0;
            repeat_pending_next = '0;
            byte_slot_next      = 2'd0;
            partial_next        = '0;
            error_next          = ST_OK;
        end
    end

    assign result_valid = step && (emit || step_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            elements_left_reg  <= '0;
            run_left_reg       <= '0;
            repeat_pending_reg <= '0;
            byte_slot_reg      <= 2'd0;
            partial_reg        <= '0;
            error_reg          <= ST_OK;
        end
        else
        begin
            phase_reg          <= phase_next;
            elements_left_reg  <= elements_left_next;
            run_left_reg       <= run_left_next;
            repeat_pending_reg <= repeat_pending_next;
            byte_slot_reg      <= byte_slot_next;
            partial_reg        <= partial_next;
            error_reg          <= error_next;
        end
    end

endmodule

### src/strided_run_length_decoder_top.sv
// Strided run-length decoder.
// The input channel (in_valid, in_stall) carries one encoded byte per request,
// with last_byte marking the final byte of a stream. Each byte is captured in
// an input register and decoded against the running stream state once the
// output register is free; a completed element, or any byte with last_byte
// set, produces one request on the output channel (out_valid, out_stall).
// Bytes that only open a run or gather part of a four-byte element produce
// nothing. The result is registered in the output register and shows on
// out_valid. One byte can be accepted every cycle while out_stall is low;
// the only limit is the single decode step between the input register and
// the output register.
// When the receiver holds out_stall high, the output register keeps its
// request, the input register stops draining, and in_stall rises once the
// input register is also occupied. Nothing is dropped.
// Configuration (stride_four, element_total) is written through cfg_valid,
// cfg_ready, cfg_index and cfg_data, by the user only while no stream data is
// in flight, which the block itself does not enforce; the port is always ready.
// element_total is latched into the element countdown by a stream's first byte.
// Reset clears both configuration registers to zero, empties the pipeline and
// puts the decoder at the start of a stream.
`timescale 1ns / 1ps

module strided_run_length_decoder_top #(
    parameter int TOTAL_BITS = srld_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  has_element,
    output logic [srld_pkg::ELEMENT_BITS-1:0]     element_value,
    output logic [srld_pkg::COUNT_BITS-1:0]       repeat_count,
    output logic                                  stream_done,
    output logic [srld_pkg::STATUS_BITS-1:0]      status,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [srld_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [srld_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import srld_pkg::*;

    // Configuration registers.
    logic                       stride_four_reg;
    logic [TOTAL_CFG_BITS-1:0]  element_total_reg;
    logic [TOTAL_BITS-1:0]      total_load;

    // Input register.
    logic                       in_full_reg, in_full_next;
    logic [7:0]                 byte_reg;
    logic                       last_reg;

    // Output register.
    logic                       out_full_reg, out_full_next;
    result_t                    result_reg;

    logic                       out_free;
    logic                       advance;
    logic                       in_take;
    logic                       core_valid;
    result_t                    core_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_four_reg   <= 1'b0;
            element_total_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STRIDE_FOUR:   stride_four_reg   <= cfg_data[0];
                CFG_ELEMENT_TOTAL: element_total_reg <= cfg_data[TOTAL_CFG_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // The countdown takes the low bits of the total, or the whole total
    // zero-extended when the countdown is wider than the register.
    generate
        if (TOTAL_BITS > TOTAL_CFG_BITS)
        begin : g_total_wide
            assign total_load = {{(TOTAL_BITS-TOTAL_CFG_BITS){1'b0}}, element_total_reg};
        end
        else
        begin : g_total_narrow
            assign total_load = element_total_reg[TOTAL_BITS-1:0];
        end
    endgenerate

    // The decode step runs whenever the input register holds a byte and the
    // output register is empty or being emptied this cycle.
    assign out_free = !out_full_reg || !out_stall;
    assign advance  = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_full_next  = in_take || (in_full_reg && !advance);
    assign out_full_next = (advance && core_valid) || (out_full_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // Payload registers carry no reset; the full flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (advance && core_valid)
        begin
            result_reg <= core_result;
        end
    end

    srld_core #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .step_byte    (byte_reg),
        .step_last    (last_reg),
        .stride_four  (stride_four_reg),
        .total_load   (total_load),
        .result_valid (core_valid),
        .result       (core_result)
    );

    assign out_valid     = out_full_reg;
    assign has_element   = result_reg.has_element;
    assign element_value = result_reg.element_value;
    assign repeat_count  = result_reg.repeat_count;
    assign stream_done   = result_reg.stream_done;
    assign status        = result_reg.status;

endmodule
